// ===== rtl/symrk_pkg.sv =====
// Shared constants, types and codes for the symmetric rank-k update block.
`timescale 1ns / 1ps

package symrk_pkg;

    // Matrix limits
    localparam int MAX_N = 32;
    localparam int MAX_K = 32;
    localparam int A_DIM = (MAX_N > MAX_K) ? MAX_N : MAX_K;

    // Field widths fixed by the interface
    localparam int DATA_W    = 32;
    localparam int IDX_W     = 5;
    localparam int SIZE_W    = 6;
    localparam int CFG_IDX_W = 3;
    localparam int FRAC_W    = 16;

    // Store geometry
    localparam int A_IDX_W  = $clog2(A_DIM);
    localparam int N_IDX_W  = $clog2(MAX_N);
    localparam int K_IDX_W  = $clog2(MAX_K);
    localparam int A_ADDR_W = 2 * A_IDX_W;
    localparam int C_ADDR_W = 2 * N_IDX_W;
    localparam int A_DEPTH  = A_DIM * A_DIM;
    localparam int C_DEPTH  = MAX_N * MAX_N;

    // Arithmetic widths: products carry 32 fraction bits, the final sum 48.
    localparam int MUL_W   = DATA_W + 1;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int SUM_W   = 2 * DATA_W + K_IDX_W;
    localparam int ACC_W   = SUM_W + DATA_W;
    localparam int DROP_W  = DATA_W;
    localparam int Q_W     = ACC_W - DROP_W;
    localparam int CHUNK_W = 2;
    localparam logic [CHUNK_W-1:0] LAST_CHUNK = CHUNK_W'(2);

    localparam logic [DATA_W-1:0] SAT_POS = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_NEG = {1'b1, {(DATA_W-1){1'b0}}};

    // Operation codes of an input item
    typedef enum logic [1:0] {
        OP_WRITE_A = 2'd0,
        OP_WRITE_C = 2'd1,
        OP_RUN     = 2'd2,
        OP_READ_C  = 2'd3
    } op_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_N     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_K     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA  = 3'd5;

    // Result kinds
    localparam logic KIND_RUN  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_PUT,
        ST_ELEM,
        ST_MAC_RA,
        ST_MAC_RB,
        ST_MAC_MUL,
        ST_MAC_ACC,
        ST_ALPHA_MUL,
        ST_ALPHA_ACC,
        ST_C_RD,
        ST_C_MUL,
        ST_C_ACC,
        ST_ABS,
        ST_ROUND
    } state_t;

endpackage

// ===== rtl/symrk_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module symrk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/symmetric_rank_k_update.sv =====
// Top level of the symmetric rank-k update block: sequencer, shared multiplier and stores.
`timescale 1ns / 1ps

// Channel   Signals                                   Direction  Transfer when
// item      item_valid/item_ready, operation, row,    in         item_valid && item_ready
//           col, value
// result    result_valid/result_ready, result_kind,   out        result_valid && result_ready
//           read_value, saturated
// config    cfg_write, cfg_index, cfg_data            in         cfg_write (no handshake)
//
// Writes of A or C elements can be accepted back to back.
// A read of C passes through the memory read, then the output load, before its result.
// In a run, each element of the triangle walks K multiply-accumulates through the single
// 33x33 multiplier, with the two A operands fetched one after the other from the A store's
// only read port, then three partial products with alpha (both skipped when K is zero),
// one product with beta and two rounding steps.
// Reset clears the control state and the sticky saturation flag; the stores are not cleared.
// While a run or read is in progress item_ready is low; a stalled result holds the block
// in the output state until the result register frees up.

module symmetric_rank_k_update (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Item channel
    input  logic                                   item_valid,
    output logic                                   item_ready,
    input  logic [1:0]                             operation,
    input  logic [symrk_pkg::IDX_W-1:0]            row,
    input  logic [symrk_pkg::IDX_W-1:0]            col,
    input  logic signed [symrk_pkg::DATA_W-1:0]    value,
    // Result channel
    output logic                                   result_valid,
    input  logic                                   result_ready,
    output logic                                   result_kind,
    output logic signed [symrk_pkg::DATA_W-1:0]    read_value,
    output logic                                   saturated,
    // Configuration port
    input  logic                                   cfg_write,
    input  logic [symrk_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [symrk_pkg::DATA_W-1:0]           cfg_data
);

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    symrk_pkg::state_t state_reg, state_next;

    // Configuration registers
    logic                                lower_reg;
    logic                                trans_reg;
    logic [symrk_pkg::SIZE_W-1:0]        size_n_reg;
    logic [symrk_pkg::SIZE_W-1:0]        size_k_reg;
    logic signed [symrk_pkg::DATA_W-1:0] alpha_reg;
    logic signed [symrk_pkg::DATA_W-1:0] beta_reg;

    // Run parameters captured when a run starts
    logic                                run_lower_reg, run_lower_next;
    logic                                run_trans_reg, run_trans_next;
    logic [symrk_pkg::SIZE_W-1:0]        run_n_reg, run_n_next;
    logic [symrk_pkg::SIZE_W-1:0]        run_k_reg, run_k_next;

    // Loop counters
    logic [symrk_pkg::N_IDX_W-1:0]       i_reg, i_next;
    logic [symrk_pkg::N_IDX_W-1:0]       j_reg, j_next;
    logic [symrk_pkg::K_IDX_W-1:0]       l_reg, l_next;
    logic [symrk_pkg::CHUNK_W-1:0]       chunk_reg, chunk_next;

    // Arithmetic datapath
    logic signed [symrk_pkg::SUM_W-1:0]  sum_reg, sum_next;
    logic signed [symrk_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic signed [symrk_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic signed [symrk_pkg::DATA_W-1:0] opa_reg, opa_next;
    logic                                neg_reg, neg_next;
    logic signed [symrk_pkg::MUL_W-1:0]  mul_a;
    logic signed [symrk_pkg::MUL_W-1:0]  mul_b;
    logic signed [symrk_pkg::ACC_W-1:0]  alpha_term;

    // Rounding
    logic [symrk_pkg::ACC_W-1:0]         rnd;
    logic [symrk_pkg::Q_W-1:0]           rnd_q;
    logic [symrk_pkg::Q_W-1:0]           rnd_lim;
    logic                                sat_hit;
    logic [symrk_pkg::DATA_W-1:0]        round_value;

    // Sticky flag and result staging
    logic                                sat_reg, sat_next;
    logic                                res_kind_reg, res_kind_next;
    logic [symrk_pkg::DATA_W-1:0]        res_value_reg, res_value_next;
    logic                                out_valid_reg, out_valid_next;
    logic                                out_kind_reg, out_kind_next;
    logic [symrk_pkg::DATA_W-1:0]        out_value_reg, out_value_next;
    logic                                out_sat_reg, out_sat_next;

    // Store ports
    logic                                a_we;
    logic [symrk_pkg::A_ADDR_W-1:0]      a_waddr;
    logic [symrk_pkg::A_ADDR_W-1:0]      a_raddr;
    logic [symrk_pkg::DATA_W-1:0]        a_rdata;
    logic                                c_we;
    logic [symrk_pkg::C_ADDR_W-1:0]      c_waddr;
    logic [symrk_pkg::DATA_W-1:0]        c_wdata;
    logic [symrk_pkg::C_ADDR_W-1:0]      c_raddr;
    logic [symrk_pkg::DATA_W-1:0]        c_rdata;

    // Derived control
    logic                                accept;
    logic                                out_free;
    logic [symrk_pkg::SIZE_W-1:0]        n_eff;
    logic [symrk_pkg::SIZE_W-1:0]        k_eff;
    logic [symrk_pkg::SIZE_W-1:0]        n_last;
    logic [symrk_pkg::SIZE_W-1:0]        k_last;
    logic                                l_last;
    logic                                i_last;
    logic                                j_last;
    logic [symrk_pkg::A_IDX_W-1:0]       a_i;
    logic [symrk_pkg::A_IDX_W-1:0]       a_j;
    logic [symrk_pkg::A_IDX_W-1:0]       a_l;

    // ------------------------------------------------------------------
    // Stores
    // ------------------------------------------------------------------
    symrk_ram #(
        .WIDTH (symrk_pkg::DATA_W),
        .DEPTH (symrk_pkg::A_DEPTH)
    ) u_a_store (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (value),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    symrk_ram #(
        .WIDTH (symrk_pkg::DATA_W),
        .DEPTH (symrk_pkg::C_DEPTH)
    ) u_c_store (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    // ------------------------------------------------------------------
    // Derived control signals
    // ------------------------------------------------------------------
    assign accept   = item_valid && item_ready;
    assign out_free = !out_valid_reg || result_ready;

    // Sizes above the limits act as the limits.
    assign n_eff = (size_n_reg > symrk_pkg::SIZE_W'(symrk_pkg::MAX_N))
                 ? symrk_pkg::SIZE_W'(symrk_pkg::MAX_N) : size_n_reg;
    assign k_eff = (size_k_reg > symrk_pkg::SIZE_W'(symrk_pkg::MAX_K))
                 ? symrk_pkg::SIZE_W'(symrk_pkg::MAX_K) : size_k_reg;

    assign n_last = run_n_reg - symrk_pkg::SIZE_W'(1);
    assign k_last = run_k_reg - symrk_pkg::SIZE_W'(1);
    assign l_last = (symrk_pkg::SIZE_W'(l_reg) == k_last);
    assign j_last = (symrk_pkg::SIZE_W'(j_reg) == n_last);
    // Lower triangle walks i from j down to the last row, upper from row 0 to j.
    assign i_last = run_lower_reg ? (symrk_pkg::SIZE_W'(i_reg) == n_last)
                                  : (i_reg == j_reg);

    assign a_i = symrk_pkg::A_IDX_W'(i_reg);
    assign a_j = symrk_pkg::A_IDX_W'(j_reg);
    assign a_l = symrk_pkg::A_IDX_W'(l_reg);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            symrk_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (symrk_pkg::op_t'(operation))
                        symrk_pkg::OP_RUN:
                        begin
                            state_next = (n_eff == '0) ? symrk_pkg::ST_PUT
                                                       : symrk_pkg::ST_ELEM;
                        end
                        symrk_pkg::OP_READ_C:
                        begin
                            state_next = symrk_pkg::ST_READ;
                        end
                        default:
                        begin
                            state_next = symrk_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            symrk_pkg::ST_READ:
            begin
                state_next = symrk_pkg::ST_PUT;
            end
            symrk_pkg::ST_PUT:
            begin
                if (out_free)
                begin
                    state_next = symrk_pkg::ST_IDLE;
                end
            end
            symrk_pkg::ST_ELEM:
            begin
                state_next = (run_k_reg == '0) ? symrk_pkg::ST_C_RD : symrk_pkg::ST_MAC_RA;
            end
            symrk_pkg::ST_MAC_RA:
            begin
                state_next = symrk_pkg::ST_MAC_RB;
            end
            symrk_pkg::ST_MAC_RB:
            begin
                state_next = symrk_pkg::ST_MAC_MUL;
            end
            symrk_pkg::ST_MAC_MUL:
            begin
                state_next = symrk_pkg::ST_MAC_ACC;
            end
            symrk_pkg::ST_MAC_ACC:
            begin
                state_next = l_last ? symrk_pkg::ST_ALPHA_MUL : symrk_pkg::ST_MAC_RA;
            end
            symrk_pkg::ST_ALPHA_MUL:
            begin
                state_next = symrk_pkg::ST_ALPHA_ACC;
            end
            symrk_pkg::ST_ALPHA_ACC:
            begin
                state_next = (chunk_reg == symrk_pkg::LAST_CHUNK) ? symrk_pkg::ST_C_RD
                                                                   : symrk_pkg::ST_ALPHA_MUL;
            end
            symrk_pkg::ST_C_RD:
            begin
                state_next = symrk_pkg::ST_C_MUL;
            end
            symrk_pkg::ST_C_MUL:
            begin
                state_next = symrk_pkg::ST_C_ACC;
            end
            symrk_pkg::ST_C_ACC:
            begin
                state_next = symrk_pkg::ST_ABS;
            end
            symrk_pkg::ST_ABS:
            begin
                state_next = symrk_pkg::ST_ROUND;
            end
            symrk_pkg::ST_ROUND:
            begin
                state_next = (i_last && j_last) ? symrk_pkg::ST_PUT : symrk_pkg::ST_ELEM;
            end
            default:
            begin
                state_next = symrk_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer outputs: handshake, store ports and multiplier operands
    // ------------------------------------------------------------------
    always_comb
    begin
        item_ready = (state_reg == symrk_pkg::ST_IDLE);

        // Item writes go straight into the stores at the transfer.
        a_we    = 1'b0;
        a_waddr = {symrk_pkg::A_IDX_W'(row), symrk_pkg::A_IDX_W'(col)};
        c_we    = 1'b0;
        c_waddr = {symrk_pkg::N_IDX_W'(row), symrk_pkg::N_IDX_W'(col)};
        c_wdata = value;
        c_raddr = {symrk_pkg::N_IDX_W'(row), symrk_pkg::N_IDX_W'(col)};

        // The first A operand is A(i,l), or A(l,i) when transposed.
        a_raddr = run_trans_reg ? {a_l, a_i} : {a_i, a_l};

        mul_a = symrk_pkg::MUL_W'(opa_reg);
        mul_b = symrk_pkg::MUL_W'($signed(a_rdata));

        case (state_reg)
            symrk_pkg::ST_IDLE:
            begin
                a_we = accept && (symrk_pkg::op_t'(operation) == symrk_pkg::OP_WRITE_A);
                c_we = accept && (symrk_pkg::op_t'(operation) == symrk_pkg::OP_WRITE_C);
            end
            symrk_pkg::ST_MAC_RB:
            begin
                a_raddr = run_trans_reg ? {a_l, a_j} : {a_j, a_l};
            end
            symrk_pkg::ST_ALPHA_MUL:
            begin
                // The sum is split into two unsigned 32-bit chunks and a signed top.
                case (chunk_reg)
                    symrk_pkg::CHUNK_W'(0):
                    begin
                        mul_a = $signed({1'b0, sum_reg[symrk_pkg::DATA_W-1:0]});
                    end
                    symrk_pkg::CHUNK_W'(1):
                    begin
                        mul_a = $signed({1'b0,
                            sum_reg[2*symrk_pkg::DATA_W-1:symrk_pkg::DATA_W]});
                    end
                    default:
                    begin
                        mul_a = symrk_pkg::MUL_W'(
                            $signed(sum_reg[symrk_pkg::SUM_W-1:2*symrk_pkg::DATA_W]));
                    end
                endcase
                mul_b = symrk_pkg::MUL_W'(alpha_reg);
            end
            symrk_pkg::ST_C_RD:
            begin
                c_raddr = {i_reg, j_reg};
            end
            symrk_pkg::ST_C_MUL:
            begin
                mul_a = symrk_pkg::MUL_W'($signed(c_rdata));
                mul_b = symrk_pkg::MUL_W'(beta_reg);
            end
            symrk_pkg::ST_ROUND:
            begin
                c_we    = 1'b1;
                c_waddr = {i_reg, j_reg};
                c_wdata = round_value;
            end
            default:
            begin
                a_we = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Rounding: magnitude plus one half, drop 32 fraction bits, saturate.
    // ------------------------------------------------------------------
    always_comb
    begin
        rnd     = acc_reg + (symrk_pkg::ACC_W'(1) << (symrk_pkg::DROP_W - 1));
        rnd_q   = rnd[symrk_pkg::ACC_W-1:symrk_pkg::DROP_W];
        // A negative result may reach exactly -2^31, a positive one only 2^31 - 1.
        rnd_lim = (symrk_pkg::Q_W'(1) << (symrk_pkg::DATA_W - 1))
                - symrk_pkg::Q_W'(!neg_reg);
        sat_hit = (rnd_q > rnd_lim);
        if (sat_hit)
        begin
            round_value = neg_reg ? symrk_pkg::SAT_NEG : symrk_pkg::SAT_POS;
        end
        else
        begin
            round_value = neg_reg ? (symrk_pkg::DATA_W'(0) - rnd_q[symrk_pkg::DATA_W-1:0])
                                  : rnd_q[symrk_pkg::DATA_W-1:0];
        end
    end

    // Partial product with alpha, moved to the weight of its chunk.
    always_comb
    begin
        case (chunk_reg)
            symrk_pkg::CHUNK_W'(0):
            begin
                alpha_term = symrk_pkg::ACC_W'(prod_reg);
            end
            symrk_pkg::CHUNK_W'(1):
            begin
                alpha_term = symrk_pkg::ACC_W'(prod_reg) <<< symrk_pkg::DATA_W;
            end
            default:
            begin
                alpha_term = symrk_pkg::ACC_W'(prod_reg) <<< (2 * symrk_pkg::DATA_W);
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and counter next values
    // ------------------------------------------------------------------
    always_comb
    begin
        run_lower_next = run_lower_reg;
        run_trans_next = run_trans_reg;
        run_n_next     = run_n_reg;
        run_k_next     = run_k_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        l_next         = l_reg;
        chunk_next     = chunk_reg;
        sum_next       = sum_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        opa_next       = opa_reg;
        neg_next       = neg_reg;
        sat_next       = sat_reg;
        res_kind_next  = res_kind_reg;
        res_value_next = res_value_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_kind_next  = out_kind_reg;
        out_value_next = out_value_reg;
        out_sat_next   = out_sat_reg;

        case (state_reg)
            symrk_pkg::ST_IDLE:
            begin
                if (accept && (symrk_pkg::op_t'(operation) == symrk_pkg::OP_RUN))
                begin
                    run_lower_next = lower_reg;
                    run_trans_next = trans_reg;
                    run_n_next     = n_eff;
                    run_k_next     = k_eff;
                    i_next         = '0;
                    j_next         = '0;
                    res_kind_next  = symrk_pkg::KIND_RUN;
                    res_value_next = '0;
                end
                if (accept && (symrk_pkg::op_t'(operation) == symrk_pkg::OP_READ_C))
                begin
                    res_kind_next = symrk_pkg::KIND_READ;
                end
            end
            symrk_pkg::ST_READ:
            begin
                res_value_next = c_rdata;
            end
            symrk_pkg::ST_PUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = res_kind_reg;
                    out_value_next = res_value_reg;
                    out_sat_next   = sat_reg;
                end
            end
            symrk_pkg::ST_ELEM:
            begin
                sum_next   = '0;
                acc_next   = '0;
                l_next     = '0;
                chunk_next = '0;
            end
            symrk_pkg::ST_MAC_RB:
            begin
                opa_next = $signed(a_rdata);
            end
            symrk_pkg::ST_MAC_MUL, symrk_pkg::ST_ALPHA_MUL, symrk_pkg::ST_C_MUL:
            begin
                prod_next = mul_a * mul_b;
            end
            symrk_pkg::ST_MAC_ACC:
            begin
                sum_next = sum_reg + symrk_pkg::SUM_W'(prod_reg);
                l_next   = l_reg + symrk_pkg::K_IDX_W'(1);
            end
            symrk_pkg::ST_ALPHA_ACC:
            begin
                acc_next   = acc_reg + alpha_term;
                chunk_next = chunk_reg + symrk_pkg::CHUNK_W'(1);
            end
            symrk_pkg::ST_C_ACC:
            begin
                // beta*C has 32 fraction bits; the accumulator keeps 48.
                acc_next = acc_reg + (symrk_pkg::ACC_W'(prod_reg) <<< symrk_pkg::FRAC_W);
            end
            symrk_pkg::ST_ABS:
            begin
                neg_next = acc_reg[symrk_pkg::ACC_W-1];
                acc_next = acc_reg[symrk_pkg::ACC_W-1] ? -acc_reg : acc_reg;
            end
            symrk_pkg::ST_ROUND:
            begin
                sat_next = sat_reg || sat_hit;
                if (i_last)
                begin
                    j_next = j_reg + symrk_pkg::N_IDX_W'(1);
                    i_next = run_lower_reg ? (j_reg + symrk_pkg::N_IDX_W'(1)) : '0;
                end
                else
                begin
                    i_next = i_reg + symrk_pkg::N_IDX_W'(1);
                end
            end
            default:
            begin
                sat_next = sat_reg;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= symrk_pkg::ST_IDLE;
            lower_reg     <= 1'b0;
            trans_reg     <= 1'b0;
            size_n_reg    <= '0;
            size_k_reg    <= '0;
            alpha_reg     <= symrk_pkg::DATA_W'(1) << symrk_pkg::FRAC_W;
            beta_reg      <= symrk_pkg::DATA_W'(1) << symrk_pkg::FRAC_W;
            run_lower_reg <= 1'b0;
            run_trans_reg <= 1'b0;
            run_n_reg     <= '0;
            run_k_reg     <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            l_reg         <= '0;
            chunk_reg     <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_lower_reg <= run_lower_next;
            run_trans_reg <= run_trans_next;
            run_n_reg     <= run_n_next;
            run_k_reg     <= run_k_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            l_reg         <= l_next;
            chunk_reg     <= chunk_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    symrk_pkg::CFG_LOWER: lower_reg  <= cfg_data[0];
                    symrk_pkg::CFG_TRANS: trans_reg  <= cfg_data[0];
                    symrk_pkg::CFG_N:     size_n_reg <= cfg_data[symrk_pkg::SIZE_W-1:0];
                    symrk_pkg::CFG_K:     size_k_reg <= cfg_data[symrk_pkg::SIZE_W-1:0];
                    symrk_pkg::CFG_ALPHA: alpha_reg  <= $signed(cfg_data);
                    symrk_pkg::CFG_BETA:  beta_reg   <= $signed(cfg_data);
                    default:              lower_reg  <= lower_reg;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        sum_reg       <= sum_next;
        acc_reg       <= acc_next;
        prod_reg      <= prod_next;
        opa_reg       <= opa_next;
        neg_reg       <= neg_next;
        res_kind_reg  <= res_kind_next;
        res_value_reg <= res_value_next;
        out_kind_reg  <= out_kind_next;
        out_value_reg <= out_value_next;
        out_sat_reg   <= out_sat_next;
    end

    assign result_valid = out_valid_reg;
    assign result_kind  = out_kind_reg;
    assign read_value   = $signed(out_value_reg);
    assign saturated    = out_sat_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A run only ever writes back into the chosen triangle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == symrk_pkg::ST_ROUND)
        |-> (run_lower_reg ? (i_reg >= j_reg) : (i_reg <= j_reg)))
    else $error("run writes C outside the chosen triangle");

    // Element indices stay inside the captured order of C.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == symrk_pkg::ST_ROUND)
        |-> ((symrk_pkg::SIZE_W'(i_reg) < run_n_reg) && (symrk_pkg::SIZE_W'(j_reg) < run_n_reg)))
    else $error("run element index beyond size_n");

    // The inner loop runs only for a nonzero K and never passes its last step.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == symrk_pkg::ST_MAC_RA) || (state_reg == symrk_pkg::ST_MAC_RB) ||
         (state_reg == symrk_pkg::ST_MAC_MUL) || (state_reg == symrk_pkg::ST_MAC_ACC))
        |-> ((run_k_reg != '0) && (symrk_pkg::SIZE_W'(l_reg) < run_k_reg)))
    else $error("inner product counter out of range");

    // A result appears only from the output state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> ($past(state_reg) == symrk_pkg::ST_PUT))
    else $error("result raised outside the output state");

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the symmetric rank-k update block.
`timescale 1ns / 1ps

// The testbench loads elements of A and C, starts update runs and reads C back.
// Every accepted item is applied to a bit-exact software copy of the block: its
// two stores, its configuration and its sticky saturation flag. Each run or read
// adds one predicted reply to a queue, and the result monitor compares every
// transfer on the result channel with the oldest entry of that queue.
//
// Stores are undefined until written, so the stimulus tracks which entries hold
// data. Before a run it loads every A element the run multiplies and every C
// element of the chosen triangle, and a read of a C entry that holds nothing is
// preceded by a write of it. Configuration changes only while the block is idle.

module tb;

    import symrk_pkg::*;

    // One input item and one predicted reply.
    typedef struct {
        op_t               op;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DATA_W-1:0] val;
    } syrk_item_t;

    typedef struct {
        logic              kind;
        logic [DATA_W-1:0] data;
        logic              sat;
    } syrk_reply_t;

    // Block ports. Everything the testbench drives starts at a known value.
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 item_valid = 1'b0;
    logic                 item_ready;
    logic [1:0]           operation = OP_WRITE_A;
    logic [IDX_W-1:0]     row = '0;
    logic [IDX_W-1:0]     col = '0;
    logic [DATA_W-1:0]    value = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    logic                 result_kind;
    logic [DATA_W-1:0]    read_value;
    logic                 saturated;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_LOWER;
    logic [DATA_W-1:0]    cfg_data = '0;

    symmetric_rank_k_update dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .operation    (operation),
        .row          (row),
        .col          (col),
        .value        (value),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_kind  (result_kind),
        .read_value   (read_value),
        .saturated    (saturated),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Software copy of the block: configuration, stores and sticky flag.
    logic                     cfg_lower = 1'b0;
    logic                     cfg_trans = 1'b0;
    logic [SIZE_W-1:0]        cfg_n = '0;
    logic [SIZE_W-1:0]        cfg_k = '0;
    logic signed [DATA_W-1:0] cfg_alpha = 32'sh0001_0000;
    logic signed [DATA_W-1:0] cfg_beta = 32'sh0001_0000;
    logic signed [DATA_W-1:0] a_mirror [A_DIM][A_DIM];
    logic signed [DATA_W-1:0] c_mirror [MAX_N][MAX_N];
    logic                     sat_sticky = 1'b0;

    // Which store entries hold data, as seen by the stimulus in item order.
    bit a_loaded [A_DIM][A_DIM];
    bit c_loaded [MAX_N][MAX_N];

    syrk_item_t  item_backlog[$];
    syrk_reply_t predicted_replies[$];
    syrk_item_t  item_on_wire;

    int mismatch_count = 0;
    int send_gap = 0;
    int hold_gap = 0;
    int gap_pct = 0;
    int stall_pct = 0;
    bit tame_fill = 1'b1;

    initial begin
        forever #2 clk = ~clk;
    end

    // Hard stop in case the block hangs; the slowest correct run is far shorter.
    initial begin
        #(20_000_000);
        $display("tb failed");
        $finish;
    end

    // One run of the update over the chosen triangle. Every element is formed
    // exactly: the dot product carries 32 fraction bits, alpha brings it to 48,
    // and beta*C is shifted up to 48 as well. The sum is rounded once to nearest
    // with ties away from zero, then clamped to the signed 32-bit range.
    task automatic rank_k_fold();
        int                  n;
        int                  k;
        logic signed [63:0]  prod;
        logic signed [63:0]  scaled_c;
        logic signed [127:0] dot;
        logic signed [127:0] beta_part;
        logic signed [127:0] total;
        logic [127:0]        mag;
        logic [127:0]        q;
        logic                neg;
        n = (cfg_n > MAX_N) ? MAX_N : int'(cfg_n);
        k = (cfg_k > MAX_K) ? MAX_K : int'(cfg_k);
        for (int j = 0; j < n; j++) begin
            for (int i = 0; i < n; i++) begin
                if (cfg_lower ? (i < j) : (i > j))
                    continue;
                dot = '0;
                for (int l = 0; l < k; l++) begin
                    prod = cfg_trans ? a_mirror[l][i] * a_mirror[l][j]
                                     : a_mirror[i][l] * a_mirror[j][l];
                    dot = dot + prod;
                end
                total = dot * cfg_alpha;
                scaled_c = c_mirror[i][j] * cfg_beta;
                beta_part = scaled_c;
                total = total + (beta_part <<< 16);
                neg = total[127];
                mag = neg ? -total : total;
                mag = mag + 128'h8000_0000;
                q = mag >> 32;
                if (q > (neg ? 128'h8000_0000 : 128'h7FFF_FFFF)) begin
                    sat_sticky = 1'b1;
                    c_mirror[i][j] = neg ? SAT_NEG : SAT_POS;
                end else begin
                    c_mirror[i][j] = neg ? (32'd0 - q[31:0]) : q[31:0];
                end
            end
        end
    endtask

    // Applies one accepted item to the software copy and records the reply due.
    task automatic predict_syrk_item(input syrk_item_t it);
        syrk_reply_t due;
        case (it.op)
            OP_WRITE_A: a_mirror[it.row][it.col] = it.val;
            OP_WRITE_C: c_mirror[it.row][it.col] = it.val;
            OP_RUN: begin
                rank_k_fold();
                due.kind = KIND_RUN;
                due.data = '0;
                due.sat = sat_sticky;
                predicted_replies.push_back(due);
            end
            default: begin
                due.kind = KIND_READ;
                due.data = c_mirror[it.row][it.col];
                due.sat = sat_sticky;
                predicted_replies.push_back(due);
            end
        endcase
    endtask

    // Item driver. A new item goes out only after the previous one was
    // transferred, so valid and payload stay put while the block holds off.
    // After a launch it may schedule a burst of idle cycles before the next.
    always @(posedge clk or negedge rst_n) begin : drive_items
        logic taken;
        if (!rst_n) begin
            item_valid <= 1'b0;
        end else begin
            taken = item_valid && item_ready;
            if (taken)
                predict_syrk_item(item_on_wire);
            if (!item_valid || taken) begin
                if (send_gap != 0) begin
                    send_gap = send_gap - 1;
                    item_valid <= 1'b0;
                end else if (item_backlog.size() != 0) begin
                    item_on_wire = item_backlog.pop_front();
                    operation <= item_on_wire.op;
                    row <= item_on_wire.row;
                    col <= item_on_wire.col;
                    value <= item_on_wire.val;
                    item_valid <= 1'b1;
                    if ($urandom_range(0, 99) < gap_pct)
                        send_gap = $urandom_range(1, 13);
                end else begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report_bad(input string msg);
        if (mismatch_count < 10)
            $display("%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Result monitor. Every transfer must match the oldest predicted reply in
    // all three fields. Ready drops in random bursts to stall the block.
    always @(posedge clk or negedge rst_n) begin : check_replies
        syrk_reply_t want;
        if (!rst_n) begin
            result_ready <= 1'b0;
        end else begin
            if (result_valid && result_ready) begin
                if (predicted_replies.size() == 0) begin
                    report_bad($sformatf("result with none due: kind %0d value %h sat %0d",
                        result_kind, read_value, saturated));
                end else begin
                    want = predicted_replies.pop_front();
                    if (result_kind !== want.kind || read_value !== want.data ||
                        saturated !== want.sat)
                        report_bad($sformatf(
                            "expected kind %0d value %h sat %0d, got kind %0d value %h sat %0d",
                            want.kind, want.data, want.sat,
                            result_kind, read_value, saturated));
                end
            end
            if (hold_gap != 0) begin
                hold_gap = hold_gap - 1;
                result_ready <= 1'b0;
            end else begin
                result_ready <= 1'b1;
                if ($urandom_range(0, 99) < stall_pct)
                    hold_gap = $urandom_range(1, 13);
            end
        end
    end

    // Element values: mostly small numbers within +/-4.0 so that rounding is
    // exercised without saturating, plus raw 32-bit patterns and the extremes.
    function automatic logic [DATA_W-1:0] pick_value();
        int sel;
        logic [DATA_W-1:0] v;
        sel = $urandom_range(0, 99);
        if (tame_fill || sel < 60) begin
            v = $urandom_range(0, 32'h7FFFF);
            v = v - 32'h40000;
        end else if (sel < 80) begin
            v = $urandom;
        end else begin
            case ($urandom_range(0, 5))
                0: v = 32'h0000_0000;
                1: v = SAT_POS;
                2: v = SAT_NEG;
                3: v = 32'h0001_0000;
                4: v = 32'hFFFF_0000;
                default: v = 32'h0000_0001;
            endcase
        end
        return v;
    endfunction

    // Scale factors for alpha and beta, extremes included.
    function automatic logic [DATA_W-1:0] pick_scale();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 7))
            0: v = 32'h0000_0000;
            1: v = 32'h0001_0000;
            2: v = 32'hFFFF_0000;
            3: v = SAT_POS;
            4: v = SAT_NEG;
            5: v = $urandom;
            default: begin
                v = $urandom_range(0, 32'h3FFFF);
                v = v - 32'h20000;
            end
        endcase
        return v;
    endfunction

    task automatic queue_item(input op_t op, input int r, input int c,
                              input logic [DATA_W-1:0] v);
        syrk_item_t it;
        it.op = op;
        it.row = IDX_W'(r);
        it.col = IDX_W'(c);
        it.val = v;
        if (op == OP_WRITE_A)
            a_loaded[r][c] = 1'b1;
        if (op == OP_WRITE_C)
            c_loaded[r][c] = 1'b1;
        item_backlog.push_back(it);
    endtask

    // A read of C, preceded by a write when the entry holds nothing yet.
    task automatic queue_c_read(input int r, input int c);
        if (!c_loaded[r][c])
            queue_item(OP_WRITE_C, r, c, pick_value());
        queue_item(OP_READ_C, r, c, $urandom);
    endtask

    // A run, preceded by loads of every operand it will touch that is still empty.
    task automatic queue_run();
        int n;
        int k;
        n = (cfg_n > MAX_N) ? MAX_N : int'(cfg_n);
        k = (cfg_k > MAX_K) ? MAX_K : int'(cfg_k);
        for (int j = 0; j < n; j++) begin
            for (int i = 0; i < n; i++) begin
                if (!(cfg_lower ? (i < j) : (i > j)) && !c_loaded[i][j])
                    queue_item(OP_WRITE_C, i, j, pick_value());
            end
        end
        for (int i = 0; i < n; i++) begin
            for (int l = 0; l < k; l++) begin
                if (cfg_trans && !a_loaded[l][i])
                    queue_item(OP_WRITE_A, l, i, pick_value());
                if (!cfg_trans && !a_loaded[i][l])
                    queue_item(OP_WRITE_A, i, l, pick_value());
            end
        end
        queue_item(OP_RUN, $urandom_range(0, 31), $urandom_range(0, 31), $urandom);
    endtask

    task automatic poke_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_LOWER: cfg_lower = data[0];
            CFG_TRANS: cfg_trans = data[0];
            CFG_N:     cfg_n = data[SIZE_W-1:0];
            CFG_K:     cfg_k = data[SIZE_W-1:0];
            CFG_ALPHA: cfg_alpha = data;
            default:   cfg_beta = data;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic program_regs(input logic lower, input logic trans,
                                input int n, input int k,
                                input logic [DATA_W-1:0] alpha,
                                input logic [DATA_W-1:0] beta);
        poke_reg(CFG_LOWER, {31'd0, lower});
        poke_reg(CFG_TRANS, {31'd0, trans});
        poke_reg(CFG_N, DATA_W'(n));
        poke_reg(CFG_K, DATA_W'(k));
        poke_reg(CFG_ALPHA, alpha);
        poke_reg(CFG_BETA, beta);
    endtask

    // Waits until every queued item went out and every reply came back, then
    // gives a trailing write time to land before the block is touched.
    // The state is sampled on the falling edge, clear of the driving edge.
    task automatic wait_quiet();
        @(negedge clk);
        while (item_backlog.size() != 0 || item_valid || predicted_replies.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Mostly load, run, read sequences over the active region, with some
    // writes and reads scattered over the whole store.
    task automatic random_phase(input int count);
        int n;
        int k;
        int sel;
        int rmax;
        int cmax;
        n = (cfg_n > MAX_N) ? MAX_N : int'(cfg_n);
        k = (cfg_k > MAX_K) ? MAX_K : int'(cfg_k);
        rmax = cfg_trans ? k : n;
        cmax = cfg_trans ? n : k;
        repeat (count) begin
            sel = $urandom_range(0, 99);
            if (sel < 22) begin
                if (rmax > 0 && cmax > 0 && $urandom_range(0, 3) != 0)
                    queue_item(OP_WRITE_A, $urandom_range(0, rmax - 1),
                               $urandom_range(0, cmax - 1), pick_value());
                else
                    queue_item(OP_WRITE_A, $urandom_range(0, 31), $urandom_range(0, 31),
                               pick_value());
            end else if (sel < 42) begin
                if (n > 0 && $urandom_range(0, 3) != 0)
                    queue_item(OP_WRITE_C, $urandom_range(0, n - 1),
                               $urandom_range(0, n - 1), pick_value());
                else
                    queue_item(OP_WRITE_C, $urandom_range(0, 31), $urandom_range(0, 31),
                               pick_value());
            end else if (sel < 52) begin
                queue_run();
            end else begin
                if (n > 0 && $urandom_range(0, 3) != 0)
                    queue_c_read($urandom_range(0, n - 1), $urandom_range(0, n - 1));
                else
                    queue_c_read($urandom_range(0, 31), $urandom_range(0, 31));
            end
        end
    endtask

    initial begin : stimulus
        int n;
        int k;
        gap_pct = 25;
        stall_pct = 25;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Stores at their corners, and a run with an empty matrix that must
        // leave everything as it was.
        program_regs(1'b0, 1'b0, 0, 0, 32'h0001_0000, 32'h0001_0000);
        queue_item(OP_WRITE_A, 31, 0, SAT_POS);
        queue_item(OP_WRITE_A, 31, 31, SAT_NEG);
        queue_item(OP_WRITE_C, 0, 0, SAT_NEG);
        queue_item(OP_WRITE_C, 31, 31, SAT_POS);
        queue_item(OP_WRITE_C, 0, 31, 32'h0001_8000);
        queue_run();
        queue_c_read(0, 0);
        queue_c_read(31, 31);
        queue_c_read(0, 31);
        wait_quiet();

        // Plain update of the upper triangle; the lower one must not move.
        program_regs(1'b0, 1'b0, 3, 2, 32'h0001_0000, 32'h0001_0000);
        queue_run();
        queue_c_read(0, 0);
        queue_c_read(0, 2);
        queue_c_read(2, 0);
        queue_c_read(1, 2);
        wait_quiet();

        // Alpha zero with beta one leaves the triangle unchanged.
        program_regs(1'b1, 1'b0, 3, 3, 32'h0000_0000, 32'h0001_0000);
        queue_run();
        queue_c_read(2, 1);
        queue_c_read(1, 2);
        wait_quiet();

        // No inner dimension and beta zero clear the lower triangle.
        program_regs(1'b1, 1'b1, 3, 0, 32'hFFFF_0000, 32'h0000_0000);
        queue_run();
        queue_c_read(2, 0);
        queue_c_read(0, 2);
        wait_quiet();

        // Beta one half on odd values lands exactly on rounding ties, both
        // signs; the size above the limit clamps to the full matrix.
        program_regs(1'b0, 1'b0, 33, 0, 32'h0000_8000, 32'h0000_8000);
        queue_item(OP_WRITE_C, 0, 0, 32'h0000_0001);
        queue_item(OP_WRITE_C, 0, 1, 32'hFFFF_FFFF);
        queue_item(OP_WRITE_C, 1, 1, 32'h0000_0003);
        queue_run();
        queue_c_read(0, 0);
        queue_c_read(0, 1);
        queue_c_read(1, 1);
        wait_quiet();

        // Largest sizes with extreme scales: results saturate both ways.
        tame_fill = 1'b0;
        program_regs(1'b1, 1'b0, 63, 63, SAT_POS, SAT_NEG);
        queue_item(OP_WRITE_A, 0, 0, SAT_NEG);
        queue_item(OP_WRITE_A, 1, 0, SAT_POS);
        queue_run();
        queue_c_read(0, 0);
        queue_c_read(31, 0);
        queue_c_read(31, 31);
        queue_c_read(0, 31);
        wait_quiet();

        // Transposed lower update at full order with a tiny alpha and beta -1.
        program_regs(1'b1, 1'b1, 32, 33, 32'h0000_0100, 32'hFFFF_0000);
        queue_run();
        queue_c_read(5, 3);
        queue_c_read(3, 5);
        queue_c_read(31, 31);
        wait_quiet();

        // Random phases, each under its own configuration. Sizes stay small
        // so runs stay short; the last phase has no idling on either side.
        for (int ph = 0; ph < 11; ph++) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(0, 6);
            k = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(0, 6);
            program_regs($urandom_range(0, 1), $urandom_range(0, 1), n, k,
                         pick_scale(), pick_scale());
            tame_fill = ($urandom_range(0, 2) == 0);
            if (ph == 10) begin
                gap_pct = 0;
                stall_pct = 0;
            end else begin
                gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
                stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
            end
            random_phase(50);
            wait_quiet();
        end

        // Leave room for any stray result before the verdict.
        repeat (24) @(posedge clk);
        if (mismatch_count == 0 && predicted_replies.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
